// ===== hdl/sapa_pkg.sv =====
package sapa_pkg;

   // request codes
   localparam logic [1:0] REQ_PAIR    = 2'd0;
   localparam logic [1:0] REQ_SINGLE  = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   localparam logic [3:0] FULL_MASK       = 4'hF;
   localparam int         PAGES_PER_SLICE = 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] slice;
      logic [1:0] count;
      logic [3:0] mask;
   } sapa_req_type;

   typedef struct packed {
      logic       found;
      logic [3:0] slice;
      logic [1:0] page;
      logic [3:0] mask;
   } sapa_rsp_type;

   // lowest clear bit of a slice mask; stops at the top page
   function automatic logic [1:0] lowest_free(input logic [3:0] used);
      logic [1:0] p;
      p = 2'd3;
      for (int k = PAGES_PER_SLICE - 2; k >= 0; k--) begin
         if (!used[k]) begin
            p = 2'(k);
         end
      end
      return p;
   endfunction

endpackage

// ===== hdl/sapa_update.sv =====
module sapa_update #(
   parameter int NUM_SLICES = 16
) (
   input  sapa_pkg::sapa_req_type req,
   input  logic [3:0]             used     [NUM_SLICES],
   output logic [3:0]             used_nxt [NUM_SLICES],
   output sapa_pkg::sapa_rsp_type rsp
);
   import sapa_pkg::*;

   localparam int IDX_W = (NUM_SLICES > 2) ? $clog2(NUM_SLICES) : 1;
   localparam int CMP_W = (IDX_W > 5) ? IDX_W : 5;

   logic             pair_ok;
   logic [IDX_W-1:0] pair_idx;
   logic             single_ok;
   logic [IDX_W-1:0] single_idx;
   logic [1:0]       single_page;
   logic [CMP_W-1:0] rel_lo;
   logic [CMP_W-1:0] rel_hi;

   // lowest free pair: scan downward so the lowest hit is kept
   always_comb begin
      pair_ok  = 1'b0;
      pair_idx = '0;
      for (int i = NUM_SLICES - 2; i >= 0; i--) begin
         if (used[i] == 4'h0 && used[i+1] == 4'h0) begin
            pair_ok  = 1'b1;
            pair_idx = IDX_W'(i);
         end
      end
   end

   // highest slice with a free page
   always_comb begin
      single_ok  = 1'b0;
      single_idx = '0;
      for (int i = 0; i < NUM_SLICES; i++) begin
         if (used[i] != FULL_MASK) begin
            single_ok  = 1'b1;
            single_idx = IDX_W'(i);
         end
      end
   end

   assign single_page = lowest_free(used[single_idx]);
   assign rel_lo      = CMP_W'(req.slice);
   assign rel_hi      = CMP_W'(req.slice) + CMP_W'(1);

   always_comb begin
      rsp = '0;
      for (int j = 0; j < NUM_SLICES; j++) begin
         used_nxt[j] = used[j];
      end
      case (req.kind)
         REQ_PAIR: begin
            if (pair_ok) begin
               used_nxt[pair_idx]               = FULL_MASK;
               used_nxt[pair_idx + IDX_W'(1)]   = FULL_MASK;
               rsp.found = 1'b1;
               rsp.slice = 4'(pair_idx);
               rsp.mask  = FULL_MASK;
            end
         end
         REQ_SINGLE: begin
            if (single_ok) begin
               used_nxt[single_idx] = used[single_idx] | (4'b0001 << single_page);
               rsp.found = 1'b1;
               rsp.slice = 4'(single_idx);
               rsp.page  = single_page;
               rsp.mask  = 4'b0001 << single_page;
            end
         end
         REQ_RELEASE: begin
            for (int j = 0; j < NUM_SLICES; j++) begin
               if ((req.count != 2'd0 && CMP_W'(j) == rel_lo) ||
                   (req.count[1] && CMP_W'(j) == rel_hi)) begin
                  used_nxt[j] = used[j] & ~req.mask;
               end
            end
            rsp.found = 1'b1;
            rsp.slice = req.slice;
            rsp.mask  = req.mask;
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

// ===== hdl/shadow_atlas_page_allocator_core.sv =====
// Shadow atlas page allocator. Holds a four-bit used-page mask per slice in
// flops, all clear after reset. Each request beat is one of: pair (lowest two
// adjacent fully free slices, both marked full), single (lowest free page of
// the highest slice that is not full), or release (clear a mask on one or two
// consecutive slices; slices past the end are ignored). Throughput is one beat
// per clock: busy is low whenever reset is low. Every request gives exactly one
// response beat. Each beat passes through the request register, while the
// single-pass search and update of the mask array runs, and then through the
// response register, which drives rsp_strobe and the fields on the ports.
// Back-to-back requests see each other's updates in order. There is no
// response backpressure; the receiver must take every beat on the cycle it
// appears. Failed allocations and request code three return all-zero fields.
module shadow_atlas_page_allocator_core #(
   parameter int NUM_SLICES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_type,
   input  logic [3:0] req_release_slice,
   input  logic [1:0] req_release_count,
   input  logic [3:0] req_release_mask,
   output logic       rsp_strobe,
   output logic       rsp_found,
   output logic [3:0] rsp_granted_slice,
   output logic [1:0] rsp_page_index,
   output logic [3:0] rsp_page_mask
);
   import sapa_pkg::*;

   logic         req_vld_ff;
   sapa_req_type req_ff;
   logic         rsp_vld_ff;
   sapa_rsp_type rsp_ff;
   sapa_rsp_type rsp_in;
   logic [3:0]   used_ff [NUM_SLICES];
   logic [3:0]   used_in [NUM_SLICES];
   logic         accept;

   // only held off while in reset
   assign busy   = reset;
   assign accept = start & ~busy;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= accept;
      end
      if (accept) begin
         req_ff <= '{kind:  req_type,
                     slice: req_release_slice,
                     count: req_release_count,
                     mask:  req_release_mask};
      end
   end

   sapa_update #(
      .NUM_SLICES (NUM_SLICES)
   ) u_update (
      .req      (req_ff),
      .used     (used_ff),
      .used_nxt (used_in),
      .rsp      (rsp_in)
   );

   // mask array and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < NUM_SLICES; i++) begin
            used_ff[i] <= 4'h0;
         end
      end else begin
         rsp_vld_ff <= req_vld_ff;
         if (req_vld_ff) begin
            for (int i = 0; i < NUM_SLICES; i++) begin
               used_ff[i] <= used_in[i];
            end
         end
      end
      if (req_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe        = rsp_vld_ff;
   assign rsp_found         = rsp_ff.found;
   assign rsp_granted_slice = rsp_ff.slice;
   assign rsp_page_index    = rsp_ff.page;
   assign rsp_page_mask     = rsp_ff.mask;

endmodule

// ===== hdl/sapa_checker.sv =====
module sapa_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_type,
   input logic [3:0] req_release_slice,
   input logic [1:0] req_release_count,
   input logic [3:0] req_release_mask,
   input logic       rsp_strobe,
   input logic       rsp_found,
   input logic [3:0] rsp_granted_slice,
   input logic [1:0] rsp_page_index,
   input logic [3:0] rsp_page_mask
);

   // every accepted beat gets a response strobe
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("response missing for accepted request");

   // no response without a request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without request");

   // failed beats carry zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |->
         (rsp_granted_slice == 4'h0 && rsp_page_index == 2'd0 && rsp_page_mask == 4'h0))
      else $error("failed response carries nonzero fields");

   // a nonzero page index only comes with a one-hot grant
   a_single_onehot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_page_index != 2'd0) |->
         (rsp_page_mask == (4'b0001 << rsp_page_index)))
      else $error("page index and page mask disagree");

endmodule

bind shadow_atlas_page_allocator_core sapa_checker u_sapa_checker (.*);

// ===== bench/tb_shadow_atlas_page_allocator_core.sv =====
`timescale 1ns / 1ps

module tb_shadow_atlas_page_allocator_core;
   import sapa_pkg::*;

   localparam int SLICE_COUNT = 16;
   // Request code three has no name in the package: it is a no-op.
   localparam logic [1:0] REQ_NONE = 2'd3;
   // Slowest correct run: ~1275 beats, each behind its largest idle gap, + pipeline, far below this.
   localparam int CYCLE_LIMIT = 200000;
   // Response comes out of the response register after the request register; leave some margin.
   localparam int DRAIN_CYCLES = 8;

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_type = REQ_NONE;
   logic [3:0] req_release_slice = '0;
   logic [1:0] req_release_count = '0;
   logic [3:0] req_release_mask = '0;
   logic       rsp_strobe;
   logic       rsp_found;
   logic [3:0] rsp_granted_slice;
   logic [1:0] rsp_page_index;
   logic [3:0] rsp_page_mask;

   // Request beats waiting to go out, and grants predicted but not yet seen.
   sapa_req_type requests_todo[$];
   sapa_rsp_type grants_due[$];

   // Shadow copy of the used-page masks.
   logic [3:0] page_used [SLICE_COUNT];

   int errors = 0;
   int cycle_count = 0;

   shadow_atlas_page_allocator_core #(
      .NUM_SLICES(SLICE_COUNT)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_release_slice(req_release_slice),
      .req_release_count(req_release_count),
      .req_release_mask (req_release_mask),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_granted_slice(rsp_granted_slice),
      .rsp_page_index   (rsp_page_index),
      .rsp_page_mask    (rsp_page_mask)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one request to the shadow masks and returns the grant it should produce.
   // Anything that fails (or code three) returns all-zero fields and leaves state alone.
   function automatic sapa_rsp_type serve_request(input logic [1:0] kind,
                                                  input logic [3:0] slice,
                                                  input logic [1:0] count,
                                                  input logic [3:0] mask);
      sapa_rsp_type grant;
      int           s;
      int           p;
      bit           done;
      grant = '0;
      done  = 1'b0;
      case (kind)
         REQ_PAIR: begin
            // lowest i with i and i+1 both empty
            for (s = 0; s < SLICE_COUNT - 1; s++) begin
               if (!done && page_used[s] == '0 && page_used[s+1] == '0) begin
                  page_used[s]   = FULL_MASK;
                  page_used[s+1] = FULL_MASK;
                  grant.found    = 1'b1;
                  grant.slice    = 4'(s);
                  grant.mask     = FULL_MASK;
                  done           = 1'b1;
               end
            end
         end
         REQ_SINGLE: begin
            // highest slice with room, then its lowest clear page
            for (s = SLICE_COUNT - 1; s >= 0; s--) begin
               if (!done && page_used[s] != FULL_MASK) begin
                  p = 0;
                  while (p < PAGES_PER_SLICE - 1 && page_used[s][p]) p++;
                  page_used[s][p] = 1'b1;
                  grant.found     = 1'b1;
                  grant.slice     = 4'(s);
                  grant.page      = 2'(p);
                  grant.mask      = 4'(1 << p);
                  done            = 1'b1;
               end
            end
         end
         REQ_RELEASE: begin
            // count 0 clears nothing, 3 acts as 2; slices past the end are dropped
            if (count >= 2'd1 && int'(slice) < SLICE_COUNT) begin
               page_used[slice] = page_used[slice] & ~mask;
            end
            if (count >= 2'd2 && int'(slice) + 1 < SLICE_COUNT) begin
               page_used[int'(slice) + 1] = page_used[int'(slice) + 1] & ~mask;
            end
            grant.found = 1'b1;
            grant.slice = slice;
            grant.mask  = mask;
         end
         default: begin
         end
      endcase
      return grant;
   endfunction

   task automatic queue_request(input logic [1:0] kind, input logic [3:0] slice,
                                input logic [1:0] count, input logic [3:0] mask);
      sapa_req_type beat;
      beat.kind  = kind;
      beat.slice = slice;
      beat.count = count;
      beat.mask  = mask;
      requests_todo.push_back(beat);
   endtask

   task automatic check_field(input string name, input logic [3:0] want,
                              input logic [3:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // Driver: one request per beat, a random idle gap in front of each beat,
   // with occasional back-to-back stretches. start is held until busy is low.
   int gap_left = 0;
   int calm_left = 0;

   always @(posedge clock) begin : driver
      sapa_req_type beat;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (requests_todo.size() != 0) begin
            beat = requests_todo.pop_front();
            req_type          <= beat.kind;
            req_release_slice <= beat.slice;
            req_release_count <= beat.count;
            req_release_mask  <= beat.mask;
            start             <= 1'b1;
            // gap ahead of the next beat
            if (calm_left > 0) begin
               calm_left--;
               gap_left = 0;
            end else if ($urandom_range(0, 19) == 0) begin
               calm_left = $urandom_range(8, 40);
               gap_left  = 0;
            end else begin
               gap_left = $urandom_range(0, 9);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predicts on each accepted request beat, checks each response beat
   // against the oldest prediction. Port values seen here are pre-edge.
   always @(posedge clock) begin : monitor
      sapa_rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            grants_due.push_back(serve_request(req_type, req_release_slice,
                                               req_release_count, req_release_mask));
         end
         if (rsp_strobe !== 1'b0) begin
            if (grants_due.size() == 0) begin
               $error("response beat with nothing expected");
               errors++;
            end else begin
               want = grants_due.pop_front();
               check_field("found", 4'(want.found), 4'(rsp_found));
               check_field("granted_slice", want.slice, rsp_granted_slice);
               check_field("page_index", 4'(want.page), 4'(rsp_page_index));
               check_field("page_mask", want.mask, rsp_page_mask);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int n;
      int phase;
      int roll;
      logic [1:0] kind;
      logic [1:0] count;
      logic [3:0] mask;

      foreach (page_used[i]) page_used[i] = '0;

      // --- directed ---
      queue_request(REQ_NONE, 4'd15, 2'd3, 4'hF);    // no-op code, fields all ones
      queue_request(REQ_RELEASE, 4'd15, 2'd0, 4'hF); // count zero: nothing cleared
      queue_request(REQ_SINGLE, 4'd0, 2'd0, 4'd0);   // empty store: top slice, page 0
      repeat (7) queue_request(REQ_PAIR, 4'd0, 2'd0, 4'd0); // pairs fill slices 0..13
      queue_request(REQ_PAIR, 4'd0, 2'd0, 4'd0);     // 14 free but 15 partial: fails
      repeat (3) queue_request(REQ_SINGLE, 4'd0, 2'd0, 4'd0); // top slice pages 1..3
      repeat (4) queue_request(REQ_SINGLE, 4'd0, 2'd0, 4'd0); // slice 14 pages 0..3
      queue_request(REQ_SINGLE, 4'd0, 2'd0, 4'd0);   // everything full: fails
      queue_request(REQ_RELEASE, 4'd15, 2'd2, 4'hF); // second slice past the end
      queue_request(REQ_RELEASE, 4'd6, 2'd3, 4'hA);  // count three acts as two
      queue_request(REQ_SINGLE, 4'd0, 2'd0, 4'd0);   // lands back on slice 15
      queue_request(REQ_RELEASE, 4'd0, 2'd2, 4'h0);  // empty mask clears nothing
      queue_request(REQ_RELEASE, 4'd0, 2'd2, 4'hF);  // frees slices 0 and 1
      queue_request(REQ_PAIR, 4'd0, 2'd0, 4'd0);     // pair at slice 0 again

      // --- random ---
      // Phases of 60 beats swing occupancy: allocate-heavy, release-heavy, mixed.
      for (n = 0; n < 1250; n++) begin
         phase = (n / 60) % 3;
         roll  = $urandom_range(0, 99);
         case (phase)
            0:       kind = (roll < 40) ? REQ_PAIR : (roll < 85) ? REQ_SINGLE :
                            (roll < 97) ? REQ_RELEASE : REQ_NONE;
            1:       kind = (roll < 15) ? REQ_PAIR : (roll < 35) ? REQ_SINGLE :
                            (roll < 96) ? REQ_RELEASE : REQ_NONE;
            default: kind = (roll < 30) ? REQ_PAIR : (roll < 62) ? REQ_SINGLE :
                            (roll < 95) ? REQ_RELEASE : REQ_NONE;
         endcase
         // mostly well-formed counts, some zero and three
         roll  = $urandom_range(0, 9);
         count = (roll < 4) ? 2'd1 : (roll < 8) ? 2'd2 : 2'($urandom_range(0, 3));
         mask  = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom_range(0, 15));
         queue_request(kind, 4'($urandom_range(0, 15)), count, mask);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // all beats out, all grants back, then let the pipeline settle
      while (requests_todo.size() != 0 || start) @(posedge clock);
      while (grants_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (grants_due.size() != 0) begin
         $error("%0d grants never arrived", grants_due.size());
         errors++;
      end
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/sapa_pkg.sv
hdl/sapa_update.sv
hdl/shadow_atlas_page_allocator_core.sv
hdl/sapa_checker.sv
bench/tb_shadow_atlas_page_allocator_core.sv
